>>> src/multi_shape_lfo_unit_assert.svh
// Assertion macros for the multi-shape LFO unit.
// Included by the top level; assumes signals clk and rst_n in scope.
`ifndef MULTI_SHAPE_LFO_UNIT_ASSERT_SVH
`define MULTI_SHAPE_LFO_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define MSL_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// next-cycle implication
`define MSL_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define MSL_ASSERT_NOW(label, pre, post, msg)
`define MSL_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

>>> src/msl_pkg.sv
// Package for the multi-shape LFO: shape and register codes, fixed widths,
// and the quarter-wave sine entry function used to build the ROM.
// No dependencies.
`default_nettype none

package msl_pkg;

  // waveform select codes
  typedef enum logic [1:0] {
    SHAPE_SINE   = 2'd0,
    SHAPE_SAW    = 2'd1,
    SHAPE_TRI    = 2'd2,
    SHAPE_SILENT = 2'd3
  } msl_shape_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_WAVE_SHAPE    = 2'd0,
    REG_FREQUENCY_Q16 = 2'd1,
    REG_RATE_SCALE    = 2'd2,
    REG_PHASE_OFFSET  = 2'd3
  } msl_reg_t;

  // step multiplier sequencer
  typedef enum logic [1:0] {
    STEP_IDLE = 2'd0,
    STEP_LOAD = 2'd1,
    STEP_RUN  = 2'd2
  } msl_step_st_t;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 36;
  localparam int FREQ_W    = 32;
  localparam int RATE_W    = 36;
  localparam int OFFS_W    = 16;
  localparam int SAW_HZ_W  = 42;
  localparam int CNT_W     = $clog2(RATE_W);
  localparam int PROD1_W   = FREQ_W + RATE_W;
  localparam int PROD2_W   = SAW_HZ_W + RATE_W;
  // the step is taken from bit 64 - PHASE_BITS of the full product
  localparam int STEP_TOP  = 64;

  localparam logic [FREQ_W-1:0]   FREQ_RESET = 32'd65536;
  localparam logic [RATE_W-1:0]   RATE_RESET = 36'd5864062014;
  // saw rate in Q16.16: 450 Hz + 550 * f
  localparam logic [SAW_HZ_W-1:0] SAW_BASE_Q16 = 42'd29491200;
  localparam logic [SAW_HZ_W-1:0] SAW_SLOPE    = 42'd550;
  localparam logic [63:0]         HALF_PI_Q30  = 64'd1686629713;

  // Quarter-wave sine entry k of 2^addr_bits, Q1.(out_bits-1), from an
  // 8-term Taylor series in Q2.30; evaluated at elaboration only.
  function automatic logic [31:0] quarter_entry(input int unsigned k,
                                                input int unsigned addr_bits,
                                                input int unsigned out_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic [63:0] vmax;
    x    = (HALF_PI_Q30 * 64'(k)) >> addr_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - term;
    v    = (sum + (64'd1 << (30 - out_bits))) >> (31 - out_bits);
    vmax = (64'd1 << (out_bits - 1)) - 64'd1;
    if (v > vmax) begin
      v = vmax;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

>>> src/multi_shape_lfo_unit.sv
// Multi-shape LFO top level: phase accumulator, sine ROM, saw/triangle
// shaping, bit-serial phase step multiplier. Uses msl_pkg and
// multi_shape_lfo_unit_assert.svh.
`default_nettype none
`include "multi_shape_lfo_unit_assert.svh"

// One sample per accepted tick, one tick per cycle sustained while in_stall
// is low. The first register stage holds the sine ROM read and the
// saw/triangle value, the second is the output register. A tick of zero
// is taken but yields no result; a silent shape yields zero and holds the
// phase. The phase steps are products of frequency and rate scale formed
// by a shift-add multiplier, one rate_scale bit per cycle: after reset and
// after each write of frequency_q16 or rate_scale the input is stalled
// while the sequencer loads and then works through the rate_scale bits.
// Writing rate_scale also clears the phase. The sine table holds
// 2^TABLE_ADDR_BITS+1 quarter-wave entries in a ROM built at elaboration.
module multi_shape_lfo_unit
  import msl_pkg::*;
#(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int OUT_BITS        = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration writes
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]            cfg_wdata,
  // sample ticks in
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_sample_tick,
  // samples out
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [OUT_BITS-1:0]       out_lfo_value
);

  localparam int TabN    = 1 << TABLE_ADDR_BITS;
  localparam int AddrW   = TABLE_ADDR_BITS + 1;
  localparam int StepLsb = STEP_TOP - PHASE_BITS;
  localparam int ExtW    = PHASE_BITS + OUT_BITS + 1;

  localparam logic [OUT_BITS-1:0] HalfVal = {1'b1, {(OUT_BITS-1){1'b0}}};
  localparam logic [OUT_BITS-1:0] MaxVal  = {1'b0, {(OUT_BITS-1){1'b1}}};

  // configuration registers
  msl_shape_t                wave_shape_r;
  logic [FREQ_W-1:0]         freq_r;
  logic [RATE_W-1:0]         rate_r;
  logic [OFFS_W-1:0]         offset_r;
  msl_reg_t                  cfg_reg;

  // oscillator state
  logic [PHASE_BITS-1:0]     phase_acc_r;
  logic [PHASE_BITS-1:0]     phase_acc_nxt;
  logic [PHASE_BITS-1:0]     sine_tri_step_r;
  logic [PHASE_BITS-1:0]     saw_step_r;

  // step multiplier
  msl_step_st_t              step_st_r;
  msl_step_st_t              step_st_nxt;
  logic                      step_load;
  logic                      step_run;
  logic                      step_last;
  logic [CNT_W-1:0]          cnt_r;
  logic [RATE_W-1:0]         md_r;
  logic [PROD1_W-1:0]        a1_r;
  logic [PROD1_W-1:0]        acc1_r;
  logic [PROD1_W-1:0]        acc1_nxt;
  logic [PROD2_W-1:0]        a2_r;
  logic [PROD2_W-1:0]        acc2_r;
  logic [PROD2_W-1:0]        acc2_nxt;
  logic [SAW_HZ_W-1:0]       saw_hz;

  // pipeline control
  logic                      pipe_en;
  logic                      in_xfer;
  logic                      tick_xfer;

  // first stage: ROM read and linear shapes
  logic [OUT_BITS-2:0]       sin_rom [0:TabN];
  logic [PHASE_BITS-1:0]     ph_sum;
  logic [1:0]                quad;
  logic [TABLE_ADDR_BITS-1:0] rom_idx;
  logic [AddrW-1:0]          rom_addr;
  logic [ExtW-1:0]           ph_ext;
  logic [OUT_BITS:0]         tri_t;
  logic [OUT_BITS-1:0]       saw_u;
  logic [OUT_BITS-1:0]       tri_w;
  logic [OUT_BITS-1:0]       saw_val;
  logic [OUT_BITS-1:0]       tri_val;
  logic [OUT_BITS-1:0]       lin_val;
  logic                      s1_valid_r;
  msl_shape_t                s1_shape_r;
  logic                      s1_neg_r;
  logic [OUT_BITS-2:0]       rom_q_r;
  logic [OUT_BITS-1:0]       s1_lin_r;

  // output stage
  logic [OUT_BITS-1:0]       sine_val;
  logic [OUT_BITS-1:0]       out_val_nxt;
  logic                      out_valid_r;
  logic [OUT_BITS-1:0]       out_val_r;

  assign cfg_reg = msl_reg_t'(cfg_index);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_shape_r <= SHAPE_SINE;
      freq_r       <= FREQ_RESET;
      rate_r       <= RATE_RESET;
      offset_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg)
        REG_WAVE_SHAPE:    wave_shape_r <= msl_shape_t'(cfg_wdata[1:0]);
        REG_FREQUENCY_Q16: freq_r       <= cfg_wdata[FREQ_W-1:0];
        REG_RATE_SCALE:    rate_r       <= cfg_wdata[RATE_W-1:0];
        REG_PHASE_OFFSET:  offset_r     <= cfg_wdata[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  // step sequencer: next state
  always_comb begin
    step_st_nxt = step_st_r;
    if (cfg_we && (cfg_reg == REG_FREQUENCY_Q16 || cfg_reg == REG_RATE_SCALE)) begin
      step_st_nxt = STEP_LOAD;
    end else begin
      unique case (step_st_r)
        STEP_IDLE: step_st_nxt = STEP_IDLE;
        STEP_LOAD: step_st_nxt = STEP_RUN;
        STEP_RUN:  step_st_nxt = step_last ? STEP_IDLE : STEP_RUN;
        default:   step_st_nxt = STEP_IDLE;
      endcase
    end
  end

  // step sequencer: outputs
  always_comb begin
    step_load = 1'b0;
    step_run  = 1'b0;
    unique case (step_st_r)
      STEP_IDLE: ;
      STEP_LOAD: step_load = 1'b1;
      STEP_RUN:  step_run  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_st_r <= STEP_LOAD;
    end else begin
      step_st_r <= step_st_nxt;
    end
  end

  // shift-add multiply: one rate_scale bit per cycle, both products at once
  assign step_last = (cnt_r == CNT_W'(RATE_W - 1));
  assign saw_hz    = SAW_BASE_Q16 + SAW_HZ_W'(freq_r) * SAW_SLOPE;
  assign acc1_nxt  = acc1_r + (md_r[0] ? a1_r : '0);
  assign acc2_nxt  = acc2_r + (md_r[0] ? a2_r : '0);

  always_ff @(posedge clk) begin
    if (step_load) begin
      cnt_r  <= '0;
      md_r   <= rate_r;
      a1_r   <= PROD1_W'(freq_r);
      a2_r   <= PROD2_W'(saw_hz);
      acc1_r <= '0;
      acc2_r <= '0;
    end else if (step_run) begin
      cnt_r  <= cnt_r + 1'b1;
      md_r   <= md_r >> 1;
      a1_r   <= a1_r << 1;
      a2_r   <= a2_r << 1;
      acc1_r <= acc1_nxt;
      acc2_r <= acc2_nxt;
      if (step_last) begin
        sine_tri_step_r <= acc1_nxt[StepLsb +: PHASE_BITS];
        saw_step_r      <= acc2_nxt[StepLsb +: PHASE_BITS];
      end
    end
  end

  // handshake: the pipeline moves unless a result is held back
  assign pipe_en   = !out_valid_r || !out_stall;
  assign in_stall  = (step_st_r != STEP_IDLE) || !pipe_en;
  assign in_xfer   = in_valid && !in_stall;
  assign tick_xfer = in_xfer && in_sample_tick;

  // phase advance per shape; silent holds
  always_comb begin
    case (wave_shape_r) inside
      SHAPE_SINE, SHAPE_TRI: phase_acc_nxt = phase_acc_r + sine_tri_step_r;
      SHAPE_SAW:             phase_acc_nxt = phase_acc_r + saw_step_r;
      default:               phase_acc_nxt = phase_acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
    end else if (cfg_we && cfg_reg == REG_RATE_SCALE) begin
      phase_acc_r <= '0;
    end else if (tick_xfer) begin
      phase_acc_r <= phase_acc_nxt;
    end
  end

  // quarter-wave sine ROM, contents fixed at elaboration
  for (genvar gk = 0; gk <= TabN; gk++) begin : g_rom
    localparam logic [31:0] QVal = quarter_entry(gk, TABLE_ADDR_BITS, OUT_BITS);
    assign sin_rom[gk] = QVal[OUT_BITS-2:0];
  end

  // sine address: quadrant folds the index
  assign ph_sum   = phase_acc_r + (PHASE_BITS'(offset_r) << (PHASE_BITS - OFFS_W));
  assign quad     = ph_sum[PHASE_BITS-1 -: 2];
  assign rom_idx  = ph_sum[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  assign rom_addr = quad[0] ? ({1'b1, {TABLE_ADDR_BITS{1'b0}}} - {1'b0, rom_idx})
                            : {1'b0, rom_idx};

  // saw and triangle from the phase scaled to OUT_BITS and OUT_BITS+1 bits
  assign ph_ext  = {phase_acc_r, {(OUT_BITS + 1){1'b0}}};
  assign tri_t   = ph_ext[PHASE_BITS +: OUT_BITS + 1];
  assign saw_u   = ph_ext[PHASE_BITS + 1 +: OUT_BITS];
  assign tri_w   = tri_t[OUT_BITS-1:0];
  // top of the saw saturates to +max
  assign saw_val = (saw_u == '0) ? MaxVal : (HalfVal - saw_u);
  // rising half: t - 3H is w - H, i.e. the sign bit flipped
  assign tri_val = tri_t[OUT_BITS] ? (tri_w ^ HalfVal)
                 : ((tri_w == '0) ? MaxVal : (HalfVal - tri_w));
  assign lin_val = (wave_shape_r == SHAPE_SAW) ? saw_val : tri_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r <= tick_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      rom_q_r    <= sin_rom[rom_addr];
      s1_shape_r <= wave_shape_r;
      s1_neg_r   <= quad[1];
      s1_lin_r   <= lin_val;
    end
  end

  // output select and sign
  assign sine_val = s1_neg_r ? (OUT_BITS'(0) - {1'b0, rom_q_r}) : {1'b0, rom_q_r};

  always_comb begin
    case (s1_shape_r)
      SHAPE_SINE:   out_val_nxt = sine_val;
      SHAPE_SILENT: out_val_nxt = '0;
      default:      out_val_nxt = s1_lin_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_val_r <= out_val_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_lfo_value = out_val_r;

  // checks
  `MSL_ASSERT_NOW(a_stall_while_step, step_st_r != STEP_IDLE, in_stall, "transfer in during step update")
  `MSL_ASSERT_NEXT(a_rate_clears_phase, cfg_we && cfg_reg == REG_RATE_SCALE, phase_acc_r == '0, "rate write did not clear phase")
  `MSL_ASSERT_NEXT(a_silent_holds, tick_xfer && !cfg_we && wave_shape_r == SHAPE_SILENT, $stable(phase_acc_r), "silent shape moved phase")
  `MSL_ASSERT_NEXT(a_silent_zero, pipe_en && s1_valid_r && s1_shape_r == SHAPE_SILENT, out_lfo_value == '0, "silent sample not zero")

endmodule

`default_nettype wire
